/* sv/slbc_pkg.sv */
// ----------------------------------------------------------------------------
// slbc_pkg
// Shared types and constants of the status LED blink code sequencer.
// ----------------------------------------------------------------------------
package slbc_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned NOW_W         = 32;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;

  localparam logic [CFG_W-1:0] PULSE_ON_RST  = 16'd100;
  localparam logic [CFG_W-1:0] PULSE_GAP_RST = 16'd100;
  localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd1000;

  // link codes
  localparam logic [1:0] CODE_BOTH   = 2'd0;
  localparam logic [1:0] CODE_NONE   = 2'd1;
  localparam logic [1:0] CODE_BUTTON = 2'd2;
  localparam logic [1:0] CODE_STALK  = 2'd3;

  // action kinds
  localparam logic [1:0] ACT_SINGLE = 2'd0;
  localparam logic [1:0] ACT_DOUBLE = 2'd1;

  // overlay kinds
  localparam logic [1:0] OVL_NONE   = 2'd0;
  localparam logic [1:0] OVL_SINGLE = 2'd1;
  localparam logic [1:0] OVL_DOUBLE = 2'd2;
  localparam logic [1:0] OVL_LONG   = 2'd3;

  // overlay timing in ms
  localparam logic [15:0] OVL_SINGLE_END_MS = 16'd100;
  localparam logic [15:0] OVL_DOUBLE_ON_MS  = 16'd100;
  localparam logic [15:0] OVL_DOUBLE_OFF_MS = 16'd200;
  localparam logic [15:0] OVL_DOUBLE_END_MS = 16'd300;
  localparam logic [15:0] OVL_LONG_END_MS   = 16'd500;

  typedef struct packed {
    logic             func;
    logic [NOW_W-1:0] now_ms;
    logic [1:0]       action_kind;
    logic             button_ready;
    logic             stalk_ready;
  } slbc_item_t;

  typedef struct packed {
    logic       led_on;
    logic       overlay_active;
    logic [1:0] link_code;
  } slbc_result_t;

endpackage

/* sv/slbc_if.sv */
// ----------------------------------------------------------------------------
// slbc_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface slbc_item_if import slbc_pkg::*; ();
  logic       valid;
  logic       ready;
  slbc_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slbc_result_if import slbc_pkg::*; ();
  logic         valid;
  logic         ready;
  slbc_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/status_led_blink_code_sequencer.sv */
// ----------------------------------------------------------------------------
// status_led_blink_code_sequencer
// Drives one status LED from timestamped action and update words.
// ----------------------------------------------------------------------------
// item_i is a valid/ready sink of input words, result_o a valid/ready source
// of result words, one result word per input word, in order. Registers
// (pulse on time, pulse gap, pattern period) are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write them only while no word is
// in flight; the block itself does not enforce it. Action words and updates
// that fall inside a running overlay pass PREP and OUT before the result
// register loads; updates that show solid on take the same path. Updates
// that show a pulse code pass PREP, DIV, EVAL and OUT: the position within
// the pattern period comes from a bit-serial remainder unit that handles
// one time bit a cycle. Updates with a zero period skip it and pass PREP,
// EVAL and OUT. One word is in work at a time, and item_i.ready is low
// while it is; it rises again as the result register loads.
// A finished result waits in an output register; the next word is taken
// meanwhile and holds in its last step until the register is free.
// Reset clears the overlay, shows code both ready with zero time stamps and
// loads the register defaults (100, 100, 1000 ms).
// ----------------------------------------------------------------------------
module status_led_blink_code_sequencer import slbc_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  slbc_item_if.sink            item_i,
  slbc_result_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CMP_W = (TIME_BITS > CFG_W + 3) ? TIME_BITS : CFG_W + 3;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]           state_q;
  slbc_item_t           item_q;
  logic [1:0]           ovl_kind_q;
  logic [TIME_BITS-1:0] ovl_start_q;
  logic [1:0]           shown_q;
  logic [TIME_BITS-1:0] code_start_q;
  logic [TIME_BITS-1:0] pos_q;
  slbc_result_t         pend_q;
  slbc_result_t         res_q;
  logic                 res_valid_q;
  logic [CFG_W-1:0]     on_q;
  logic [CFG_W-1:0]     gap_q;
  logic [CFG_W-1:0]     period_q;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] ovl_el;
  logic                 ovl_done;
  logic                 ovl_lit;
  logic                 ovl_running;
  logic [1:0]           new_code;
  logic [1:0]           act_ovl;
  logic                 code_changed;
  logic [TIME_BITS-1:0] code_el;
  logic                 div_start;
  logic                 div_done;
  logic [CFG_W-1:0]     div_rem;
  logic [CMP_W-1:0]     pos_x;
  logic [CMP_W-1:0]     win_x;
  logic [CMP_W-1:0]     win2_x;
  logic [CMP_W-1:0]     lim_x;
  logic [CMP_W-1:0]     red_x;
  logic                 eval_lit;
  logic                 res_free;

  // overlay and link code decisions for the held word
  always_comb begin
    now_t  = TIME_BITS'(item_q.now_ms);
    ovl_el = now_t - ovl_start_q;
    ovl_lit = 1'b0;
    unique case (ovl_kind_q)
      OVL_SINGLE: ovl_done = ovl_el >= TIME_BITS'(OVL_SINGLE_END_MS);
      OVL_DOUBLE: begin
        ovl_done = ovl_el >= TIME_BITS'(OVL_DOUBLE_END_MS);
        ovl_lit  = (ovl_el >= TIME_BITS'(OVL_DOUBLE_ON_MS)) &&
                   (ovl_el <  TIME_BITS'(OVL_DOUBLE_OFF_MS));
      end
      OVL_LONG:   ovl_done = ovl_el >= TIME_BITS'(OVL_LONG_END_MS);
      default:    ovl_done = 1'b1;
    endcase
    ovl_running = (ovl_kind_q != OVL_NONE) && !ovl_done;

    priority if (item_q.button_ready && item_q.stalk_ready) new_code = CODE_BOTH;
    else if (item_q.button_ready)                           new_code = CODE_BUTTON;
    else if (item_q.stalk_ready)                            new_code = CODE_STALK;
    else                                                    new_code = CODE_NONE;

    priority if (item_q.action_kind == ACT_SINGLE) act_ovl = OVL_SINGLE;
    else if (item_q.action_kind == ACT_DOUBLE)     act_ovl = OVL_DOUBLE;
    else                                           act_ovl = OVL_LONG;

    code_changed = new_code != shown_q;
    code_el      = code_changed ? '0 : (now_t - code_start_q);
    div_start    = (state_q == ST_PREP) && !item_q.func && !ovl_running &&
                   (new_code != CODE_BOTH) && (period_q != '0);
  end

  // pulse window check on the position within the period
  always_comb begin
    pos_x  = CMP_W'(pos_q);
    win_x  = CMP_W'(on_q) + CMP_W'(gap_q);
    win2_x = {win_x[CMP_W-2:0], 1'b0};
    unique case (shown_q)
      CODE_NONE:   lim_x = win_x;
      CODE_BUTTON: lim_x = win2_x;
      default:     lim_x = win2_x + win_x;
    endcase
    priority if (pos_x >= win2_x) red_x = pos_x - win2_x;
    else if (pos_x >= win_x)      red_x = pos_x - win_x;
    else                          red_x = pos_x;
    eval_lit = (win_x != '0) && (pos_x < lim_x) && (red_x < CMP_W'(on_q));
  end

  slbc_rem_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (code_el),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign res_free = !res_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ovl_kind_q   <= OVL_NONE;
      ovl_start_q  <= '0;
      shown_q      <= CODE_BOTH;
      code_start_q <= '0;
      res_valid_q  <= 1'b0;
      on_q         <= PULSE_ON_RST;
      gap_q        <= PULSE_GAP_RST;
      period_q     <= PERIOD_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PULSE_ON:  on_q     <= cfg_data_i;
          REG_PULSE_GAP: gap_q    <= cfg_data_i;
          REG_PERIOD:    period_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_OUT && res_free) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && result_o.ready) begin
        res_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (item_i.valid) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (item_q.func) begin
            ovl_kind_q  <= act_ovl;
            ovl_start_q <= now_t;
            state_q     <= ST_OUT;
          end else if (ovl_running) begin
            state_q <= ST_OUT;
          end else begin
            ovl_kind_q <= OVL_NONE;
            shown_q    <= new_code;
            if (code_changed) begin
              code_start_q <= now_t;
            end
            if (new_code == CODE_BOTH) begin
              state_q <= ST_OUT;
            end else if (period_q == '0) begin
              state_q <= ST_EVAL;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (res_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_i.valid) begin
      item_q <= item_i.data;
    end
    if (state_q == ST_PREP) begin
      pos_q <= code_el;
      if (item_q.func) begin
        pend_q <= '{led_on: 1'b0, overlay_active: 1'b1, link_code: shown_q};
      end else if (ovl_running) begin
        pend_q <= '{led_on: ovl_lit, overlay_active: 1'b1, link_code: shown_q};
      end else begin
        pend_q <= '{led_on: 1'b1, overlay_active: 1'b0, link_code: new_code};
      end
    end
    if (state_q == ST_DIV && div_done) begin
      pos_q <= TIME_BITS'(div_rem);
    end
    if (state_q == ST_EVAL) begin
      pend_q <= '{led_on: eval_lit, overlay_active: 1'b0, link_code: shown_q};
    end
    if (state_q == ST_OUT && res_free) begin
      res_q <= pend_q;
    end
  end

  assign item_i.ready   = state_q == ST_IDLE;
  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  a_div_only_with_period: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> period_q != '0
  ) else $error("remainder running with zero period");

  a_div_done_to_eval: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && div_done |=> state_q == ST_EVAL
  ) else $error("remainder result not taken");

  a_action_sets_overlay: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PREP && item_q.func |=> ovl_kind_q != OVL_NONE
  ) else $error("action word left no overlay");

  a_both_ready_lit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.overlay_active && res_q.link_code == CODE_BOTH |-> res_q.led_on
  ) else $error("both links ready but led dark");

endmodule

/* sv/slbc_rem_unit.sv */
// ----------------------------------------------------------------------------
// slbc_rem_unit
// Bit-serial restoring remainder of a time value by a 16-bit period,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module slbc_rem_unit import slbc_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TIME_BITS-1:0] dividend_i,
  input  logic [CFG_W-1:0]     divisor_i,
  output logic                 done_o,
  output logic [CFG_W-1:0]     rem_o
);

  localparam int unsigned CNT_W = $clog2(TIME_BITS + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [TIME_BITS-1:0] dvd_q;
  logic [CFG_W-1:0]     div_q;
  logic [CFG_W-1:0]     rem_q;
  logic [CFG_W:0]       trial;
  logic [CFG_W:0]       diff;
  logic [CFG_W-1:0]     rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[TIME_BITS-1]};
    diff  = trial - {1'b0, div_q};
    rem_d = (trial >= {1'b0, div_q}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(TIME_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
